[src/ssag_pkg.sv]
// ----------------------------------------------------------------------------
// Spiral scan address generator package
// Shared codes and start-cell tables for the spiral walk.
// ----------------------------------------------------------------------------
package ssag_pkg;

  typedef logic [1:0] dir_t;

  // Heading codes, also used for the configured first step
  localparam dir_t DIR_LEFT  = 2'd0;
  localparam dir_t DIR_UP    = 2'd1;
  localparam dir_t DIR_RIGHT = 2'd2;
  localparam dir_t DIR_DOWN  = 2'd3;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SIDE_SIZE  = 2'd0;
  localparam cfg_idx_t CFG_START_DIR  = 2'd1;
  localparam cfg_idx_t CFG_TURN_SENSE = 2'd2;

  localparam logic TURN_CW  = 1'b0;
  localparam logic TURN_CCW = 1'b1;

  // Even-side start cell: offset below n/2, indexed [turn_sense][start_dir]
  localparam logic EVEN_ROW_OFF [2][4] = '{'{1'b0, 1'b0, 1'b1, 1'b1},
                                          '{1'b1, 1'b0, 1'b0, 1'b1}};
  localparam logic EVEN_COL_OFF [2][4] = '{'{1'b0, 1'b1, 1'b1, 1'b0},
                                          '{1'b0, 1'b0, 1'b1, 1'b1}};

endpackage

[src/spiral_scan_address_generator.sv]
// ----------------------------------------------------------------------------
// Spiral scan address generator
// Walks an n-by-n square as a spiral from the center cell and emits one
// cell (row, column, sequence number, last flag) per input transfer.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload                                   | handshake
//  --------+-----------+-------------------------------------------+-------------
//  in_     | input     | restart                                   | valid/ready
//  out_    | output    | cell_row, cell_col, cell_value, last_cell | valid/ready
//  cfg_    | input     | index, data (side_size/start_dir/turn)    | valid/ready
//
//  One transfer in gives one transfer out, one per clock when the output is
//  drained. The whole step (spiral bookkeeping plus the n*n compare) is
//  combinational logic between the walk state and the output register.
//  rst_n (synchronous, active low) clears the walk; the first transfer then
//  starts a spiral. A stalled output holds its register and deasserts
//  in_ready; config writes are always taken.
//
module spiral_scan_address_generator
  import ssag_pkg::*;
#(
  parameter int MAX_SIDE = 256
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_restart,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_cell_row,
  output logic [7:0]  out_cell_col,
  output logic [16:0] out_cell_value,
  output logic        out_last_cell,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_idx_t    cfg_index,
  input  logic [8:0]  cfg_data
);

  // Effective side never exceeds the 9-bit register range
  localparam int NCAP = (MAX_SIDE < 511) ? MAX_SIDE : 511;
  localparam int NW   = $clog2(NCAP + 1);
  localparam int VW   = $clog2(NCAP * NCAP + 1);
  localparam int TW   = 2 * NW;

  // Configuration registers
  logic [8:0] side_r;
  dir_t       start_dir_r;
  logic       turn_r;

  // Walk state
  logic [7:0]    row_r, row_nxt;
  logic [7:0]    col_r, col_nxt;
  logic [VW-1:0] value_r, value_nxt;
  logic [NW-1:0] leg_len_r, leg_len_nxt;
  logic [NW-1:0] leg_step_r, leg_step_nxt;
  logic          second_r, second_nxt;
  dir_t          heading_r, heading_nxt;
  logic          final_r, final_nxt;

  // Output register
  logic          out_valid_r;
  logic [7:0]    out_row_r, out_col_r;
  logic [VW-1:0] out_value_r;
  logic          out_last_r;

  logic [NW-1:0] side_n;
  logic [TW-1:0] total;
  logic [7:0]    half;
  logic          begin_walk;
  logic [NW-1:0] step_inc;
  logic          in_xfer;
  logic [VW+16:0] value_ext;

  assign cfg_ready = 1'b1;
  assign in_ready  = out_ready || !out_valid_r;
  assign in_xfer   = in_valid && in_ready;

  // Clamp side: zero acts as one, saturate at the cap
  always_comb begin
    if (side_r == 9'd0) begin
      side_n = NW'(1);
    end else if (int'(side_r) > NCAP) begin
      side_n = NW'(NCAP);
    end else begin
      side_n = NW'(side_r);
    end
  end

  assign total = TW'(side_n) * TW'(side_n);
  assign half  = 8'(side_n >> 1);

  assign begin_walk = in_restart || (value_r == '0) || (TW'(value_r) >= total);
  assign step_inc   = NW'(leg_step_r + 1'b1);

  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    value_nxt    = value_r;
    leg_len_nxt  = leg_len_r;
    leg_step_nxt = leg_step_r;
    second_nxt   = second_r;
    heading_nxt  = heading_r;
    final_nxt    = final_r;
    if (begin_walk) begin
      // Start at the center; even sides pick a cell of the central block
      if (side_n[0]) begin
        row_nxt = half;
        col_nxt = half;
      end else begin
        row_nxt = half - 8'(EVEN_ROW_OFF[turn_r][start_dir_r]);
        col_nxt = half - 8'(EVEN_COL_OFF[turn_r][start_dir_r]);
      end
      value_nxt    = VW'(1);
      leg_len_nxt  = NW'(1);
      leg_step_nxt = '0;
      second_nxt   = 1'b0;
      heading_nxt  = start_dir_r;
      final_nxt    = 1'b0;
    end else begin
      // Move one cell along the current heading
      case (heading_r)
        DIR_LEFT:  col_nxt = col_r - 8'd1;
        DIR_UP:    row_nxt = row_r - 8'd1;
        DIR_RIGHT: col_nxt = col_r + 8'd1;
        DIR_DOWN:  row_nxt = row_r + 8'd1;
        default:   row_nxt = row_r;
      endcase
      value_nxt    = VW'(value_r + 1'b1);
      leg_step_nxt = step_inc;
      // End of leg: turn, and grow the leg after every second one
      if (step_inc >= leg_len_r) begin
        leg_step_nxt = '0;
        if (!final_r) begin
          heading_nxt = (turn_r == TURN_CW) ? dir_t'(heading_r + 2'd1)
                                            : dir_t'(heading_r + 2'd3);
          if (!second_r) begin
            second_nxt = 1'b1;
          end else begin
            second_nxt = 1'b0;
            if ((NW + 1)'(leg_len_r) + 1'b1 >= (NW + 1)'(side_n)) begin
              final_nxt = 1'b1;
            end else begin
              leg_len_nxt = NW'(leg_len_r + 1'b1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r      <= 9'd4;
      start_dir_r <= DIR_UP;
      turn_r      <= TURN_CW;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SIDE_SIZE:  side_r      <= cfg_data;
        CFG_START_DIR:  start_dir_r <= dir_t'(cfg_data);
        CFG_TURN_SENSE: turn_r      <= cfg_data[0];
        default:        side_r      <= side_r;
      endcase
    end
  end

  // Advance the walk on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      value_r    <= '0;
      leg_len_r  <= NW'(1);
      leg_step_r <= '0;
      second_r   <= 1'b0;
      heading_r  <= DIR_LEFT;
      final_r    <= 1'b0;
    end else if (in_xfer) begin
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      value_r    <= value_nxt;
      leg_len_r  <= leg_len_nxt;
      leg_step_r <= leg_step_nxt;
      second_r   <= second_nxt;
      heading_r  <= heading_nxt;
      final_r    <= final_nxt;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_row_r   <= row_nxt;
      out_col_r   <= col_nxt;
      out_value_r <= value_nxt;
      out_last_r  <= (TW'(value_nxt) == total);
    end
  end

  assign value_ext      = (VW + 17)'(out_value_r);
  assign out_valid      = out_valid_r;
  assign out_cell_row   = out_row_r;
  assign out_cell_col   = out_col_r;
  assign out_cell_value = value_ext[16:0];
  assign out_last_cell  = out_last_r;

endmodule
